// ===== rtl/array_list_shift_engine_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the array list shift engine
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_SHIFT_ENGINE_MACROS_SVH
`define ARRAY_LIST_SHIFT_ENGINE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ALE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ale assertion failed");

// Check that cons holds in the cycle after ante.
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ale assertion failed");

`endif

// ===== rtl/ale_pkg.sv =====
// ---------------------------------------------------------------------------
// ale_pkg
// Opcodes, status codes, sequencer states and the result struct.
// ---------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_FRONT  = 3'd2,
    OP_AT     = 3'd3,
    OP_SORTED = 3'd4,
    OP_REMOVE = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHR_RD,
    S_SHR_WR,
    S_SHL_RD,
    S_SHL_WR
  } state_e;

  typedef struct packed {
    logic    done;
    status_e status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ale_ram.sv =====
// ---------------------------------------------------------------------------
// ale_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ale_ctrl.sv =====
// ---------------------------------------------------------------------------
// ale_ctrl
// Sequencer with one shared index stepper and key comparator that searches
// the store and shifts entries one at a time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "array_list_shift_engine_macros.svh"

module ale_ctrl #(
  parameter int CAPACITY = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [2:0]                      opcode_i,
  input  wire logic signed [31:0]              key_i,
  input  wire logic [6:0]                      position_i,
  output logic                                 busy_o,
  output ale_pkg::res_t                        res_o,
  output logic [$clog2(CAPACITY+1)-1:0]        count_o,
  output logic                                 we_o,
  output logic [$clog2(CAPACITY)-1:0]          waddr_o,
  output logic [31:0]                          wdata_o,
  output logic                                 re_o,
  output logic [$clog2(CAPACITY)-1:0]          raddr_o,
  input  wire logic [31:0]                     rdata_i
);

  import ale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > 7) ? CW : 7;

  state_e            state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     tgt_q, tgt_d;
  logic [CW-1:0]     count_q, count_d;
  logic signed [31:0] key_q, key_d;
  logic              rm_q, rm_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;

  logic              dec;
  logic [CW-1:0]     step;
  logic              key_gt;
  logic              key_eq;
  logic              full;

  // Shared index stepper: one adder moves the pointer up or down
  assign dec  = (state_q == S_SHR_RD) || (state_q == S_SHR_WR);
  assign step = idx_q + (dec ? {CW{1'b1}} : CW'(1));

  // Shared key comparator against the entry just read
  assign key_gt = key_q > $signed(rdata_i);
  assign key_eq = key_q == $signed(rdata_i);

  assign full = (count_q == CW'(CAPACITY));

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    tgt_q <= tgt_d;
    key_q <= key_d;
    rm_q  <= rm_d;
  end

  // Next state, store access and result
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    tgt_d    = tgt_q;
    key_d    = key_q;
    rm_d     = rm_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    re_o     = 1'b0;
    raddr_o  = idx_q[AW-1:0];
    we_o     = 1'b0;
    waddr_o  = idx_q[AW-1:0];
    wdata_o  = rdata_i;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d    = key_i;
          status_d = ST_OK;
          case (opcode_e'(opcode_i))
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            OP_APPEND, OP_FRONT, OP_AT: begin
              if (full) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else if ((opcode_e'(opcode_i) == OP_AT) &&
                           (PW'(position_i) > PW'(count_q))) begin
                status_d = ST_BAD_POS;
                done_d   = 1'b1;
              end else begin
                case (opcode_e'(opcode_i))
                  OP_APPEND: tgt_d = count_q;
                  OP_FRONT:  tgt_d = '0;
                  default:   tgt_d = CW'(position_i);
                endcase
                idx_d   = count_q;
                state_d = S_SHR_RD;
              end
            end
            OP_SORTED: begin
              if (full) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                idx_d   = '0;
                rm_d    = 1'b0;
                state_d = S_SRCH_RD;
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                idx_d   = '0;
                rm_d    = 1'b1;
                state_d = S_SRCH_RD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Fetch the next entry, or end the search at the tail
      S_SRCH_RD: begin
        if (idx_q == count_q) begin
          if (rm_q) begin
            status_d = ST_NOT_FOUND;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            tgt_d   = idx_q;
            idx_d   = count_q;
            state_d = S_SHR_RD;
          end
        end else begin
          re_o    = 1'b1;
          state_d = S_SRCH_CMP;
        end
      end

      // Compare the fetched entry against the key
      S_SRCH_CMP: begin
        if (rm_q) begin
          if (key_eq) begin
            state_d = S_SHL_RD;
          end else begin
            idx_d   = step;
            state_d = S_SRCH_RD;
          end
        end else if (key_gt) begin
          idx_d   = step;
          state_d = S_SRCH_RD;
        end else begin
          tgt_d   = idx_q;
          idx_d   = count_q;
          state_d = S_SHR_RD;
        end
      end

      // Shift right down to the target, then drop the key in
      S_SHR_RD: begin
        if (idx_q == tgt_q) begin
          we_o    = 1'b1;
          waddr_o = tgt_q[AW-1:0];
          wdata_o = key_q;
          count_d = count_q + CW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = step[AW-1:0];
          state_d = S_SHR_WR;
        end
      end

      S_SHR_WR: begin
        we_o    = 1'b1;
        idx_d   = step;
        state_d = S_SHR_RD;
      end

      // Shift left over the removed entry up to the tail
      S_SHL_RD: begin
        if (step == count_q) begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = step[AW-1:0];
          state_d = S_SHL_WR;
        end
      end

      S_SHL_WR: begin
        we_o    = 1'b1;
        idx_d   = step;
        state_d = S_SHL_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_o.done   = done_q;
  assign res_o.status = status_q;
  assign count_o      = count_q;

  // Count stays within capacity
  `ALE_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY))
  // A result always leaves the sequencer ready for the next transaction
  `ALE_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_q, state_q == S_IDLE)
  // Count only moves together with a result
  `ALE_ASSERT_NEXT(a_count_done, clk_i, rst_ni, count_d != count_q, done_q)
  // Store writes never land beyond the list tail
  `ALE_ASSERT_IMPL(a_write_tail, clk_i, rst_ni, we_o, CW'(waddr_o) <= count_q)

endmodule

`default_nettype wire

// ===== rtl/array_list_shift_engine.sv =====
// ---------------------------------------------------------------------------
// array_list_shift_engine
// Fixed-capacity ordered list of signed keys with insert and remove.
// ---------------------------------------------------------------------------
// Pulse start_i while busy_o is low to issue a transaction. Exactly one
// result follows, shown for a single cycle with done_o high; it cannot be
// held off, so capture it on that cycle. Clear, rejected requests and
// unused opcodes answer in the cycle after the request. Inserts at a
// position move each entry from the tail down to the position one place
// right, then write the key; append writes the key at the tail. Sorted
// insert and remove scan the store from the head, then shift right to
// insert or left to close the gap. The steps follow from the single-read,
// single-write store with registered read data: each entry compared costs
// a read and a compare step, each entry moved a read and a write step.
// The store needs no clearing pass after reset; the count clears at once.
// ---------------------------------------------------------------------------
`default_nettype none

module array_list_shift_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic [6:0]         position_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [6:0]              entry_count_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  import ale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  res_t          res;
  logic [CW-1:0] count;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  // Sequencer and shared search/shift unit
  ale_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .opcode_i   (opcode_i),
    .key_i      (key_i),
    .position_i (position_i),
    .busy_o     (busy_o),
    .res_o      (res),
    .count_o    (count),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  // Key store
  ale_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Format the result from the updated count
  assign done_o        = res.done;
  assign status_o      = res.status;
  assign entry_count_o = 7'(count);
  assign is_empty_o    = (count == '0);
  assign is_full_o     = (count == CW'(CAPACITY));

endmodule

`default_nettype wire

// ===== tb/sv/tb_array_list_shift_engine.sv =====
// ---------------------------------------------------------------------------
// tb_array_list_shift_engine
// Self-checking bench for the ordered key list: a directed table of edge
// cases, then phased random traffic (fill, drain, mixed) with random start
// gaps. Every result is checked against the outcome typed in its row, or else
// against a queue-based shadow of the list.

module tb_array_list_shift_engine;
  import ale_pkg::*;

  localparam int          CAPACITY    = 64;
  localparam int          CLK_HALF    = 6;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_REQS = 600;
  localparam int          DRAIN_WAIT  = 150;
  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [2:0]  OP_SPARE_A  = 3'd6;
  localparam logic [2:0]  OP_SPARE_B  = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  typedef struct packed {
    status_e    status;
    logic [6:0] entry_count;
    logic       is_empty;
    logic       is_full;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [6:0]  pos;
    logic        typed;
    outcome_t    want;
  } stim_row_t;

  localparam outcome_t NO_TYPED = '{ST_OK, 7'd0, 1'b0, 1'b0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [2:0]         opcode_i = OP_CLEAR;
  logic signed [31:0] key_i = '0;
  logic [6:0]         position_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic [6:0]         entry_count_o;
  logic               is_empty_o;
  logic               is_full_o;

  // Shadow copy of the list and the outcomes still owed by the block
  logic signed [31:0] list_keys [$];
  outcome_t           pending_outcomes [$];
  outcome_t           seen;
  int                 mismatch_count = 0;
  int                 results_checked = 0;
  int                 requests_sent = 0;
  int                 status_hits [5] = '{default: 0};
  int                 cycle_count = 0;

  stim_row_t          dir_rows [25];

  array_list_shift_engine #(.CAPACITY(CAPACITY)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("tb_array_list_shift_engine: FAIL");
      $finish;
    end
  end

  // Apply one request to the shadow list and return what the block must answer
  function automatic outcome_t apply_request(logic [2:0] op, logic signed [31:0] key,
                                             logic [6:0] pos);
    outcome_t res;
    int       target;
    int       idx;
    res.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        list_keys.delete();
      end
      OP_APPEND, OP_FRONT, OP_AT: begin
        if (op == OP_APPEND) target = list_keys.size();
        else if (op == OP_FRONT) target = 0;
        else target = int'(pos);
        if (list_keys.size() >= CAPACITY) res.status = ST_FULL;
        else if (target > list_keys.size()) res.status = ST_BAD_POS;
        else list_keys.insert(target, key);
      end
      OP_SORTED: begin
        if (list_keys.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          idx = 0;
          while (idx < list_keys.size() && $signed(key) > $signed(list_keys[idx])) idx++;
          list_keys.insert(idx, key);
        end
      end
      OP_REMOVE: begin
        if (list_keys.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          idx = 0;
          while (idx < list_keys.size() && list_keys[idx] != key) idx++;
          if (idx == list_keys.size()) res.status = ST_NOT_FOUND;
          else list_keys.delete(idx);
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 7'(list_keys.size());
    res.is_empty    = (list_keys.size() == 0);
    res.is_full     = (list_keys.size() == CAPACITY);
    return res;
  endfunction

  // Drive one transaction after gap idle cycles and hold it until accepted
  task automatic send_request(input logic [2:0] op, input logic [31:0] key,
                              input logic [6:0] pos, input int gap,
                              input logic typed, input outcome_t want);
    outcome_t predicted;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    position_i <= pos;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predicted = apply_request(op, key, pos);
    pending_outcomes.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // Mix of pool values, live entries and fully random keys
  function automatic logic [31:0] pick_key();
    logic [31:0] pool [8];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd100};
    case ($urandom_range(0, 3))
      0: return pool[$urandom_range(0, 7)];
      1: begin
        if (list_keys.size() > 0) return list_keys[$urandom_range(0, list_keys.size() - 1)];
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic draw_request(input phase_e phase, output logic [2:0] op,
                              output logic [31:0] key, output logic [6:0] pos);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (r < 25) op = OP_APPEND;
        else if (r < 45) op = OP_FRONT;
        else if (r < 70) op = OP_AT;
        else if (r < 95) op = OP_SORTED;
        else op = OP_REMOVE;
      end
      PH_DRAIN: begin
        if (r < 88) op = OP_REMOVE;
        else if (r < 92) op = OP_SORTED;
        else if (r < 96) op = OP_AT;
        else op = OP_APPEND;
      end
      default: op = 3'($urandom_range(0, 7));
    endcase
    key = pick_key();
    // Removal mostly targets a live key while draining
    if (op == OP_REMOVE && phase == PH_DRAIN && list_keys.size() > 0 &&
        $urandom_range(0, 99) < 85)
      key = list_keys[$urandom_range(0, list_keys.size() - 1)];
    pos = 7'($urandom_range(0, 127));
    if (op == OP_AT) begin
      r = $urandom_range(0, 99);
      if (r < 75) pos = 7'($urandom_range(0, list_keys.size()));
      else if (r < 88) pos = 7'(list_keys.size() + $urandom_range(0, 1));
    end
  endtask

  // Check each result against the oldest owed outcome
  always @(posedge clk_i) begin
    if (rst_ni && $isunknown(done_o)) begin
      $error("done_o is unknown after reset");
      mismatch_count++;
    end else if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no transaction outstanding: status %0d count %0d",
               status_o, entry_count_o);
        mismatch_count++;
      end else begin
        seen = pending_outcomes.pop_front();
        results_checked++;
        if (int'(seen.status) < 5) status_hits[int'(seen.status)]++;
        if (status_o !== seen.status) begin
          $error("status: expected %0d, actual %0d", seen.status, status_o);
          mismatch_count++;
        end
        if (entry_count_o !== seen.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", seen.entry_count, entry_count_o);
          mismatch_count++;
        end
        if (is_empty_o !== seen.is_empty) begin
          $error("is_empty: expected %0b, actual %0b", seen.is_empty, is_empty_o);
          mismatch_count++;
        end
        if (is_full_o !== seen.is_full) begin
          $error("is_full: expected %0b, actual %0b", seen.is_full, is_full_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [2:0]  op;
    logic [31:0] key;
    logic [6:0]  pos;
    int          gap;
    phase_e      phase;

    // Directed table: edge keys, bad positions, duplicates, spare opcodes
    dir_rows = '{
      '{OP_REMOVE,  32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY,   7'd0, 1'b1, 1'b0}},
      '{OP_AT,      32'h0000_0005, 7'd1,   1'b1, '{ST_BAD_POS, 7'd0, 1'b1, 1'b0}},
      '{OP_SORTED,  32'h0000_0007, 7'd0,   1'b1, '{ST_OK,      7'd1, 1'b0, 1'b0}},
      '{OP_APPEND,  32'h7FFF_FFFF, 7'd0,   1'b1, '{ST_OK,      7'd2, 1'b0, 1'b0}},
      '{OP_FRONT,   32'h8000_0000, 7'd0,   1'b1, '{ST_OK,      7'd3, 1'b0, 1'b0}},
      '{OP_AT,      32'h0000_0000, 7'd3,   1'b1, '{ST_OK,      7'd4, 1'b0, 1'b0}},
      '{OP_AT,      32'h0000_0001, 7'd127, 1'b1, '{ST_BAD_POS, 7'd4, 1'b0, 1'b0}},
      '{OP_AT,      32'h0000_0001, 7'd5,   1'b1, '{ST_BAD_POS, 7'd4, 1'b0, 1'b0}},
      '{OP_SORTED,  32'h8000_0000, 7'd0,   1'b0, NO_TYPED},
      '{OP_SORTED,  32'hFFFF_FFFF, 7'd0,   1'b0, NO_TYPED},
      '{OP_SORTED,  32'h7FFF_FFFF, 7'd0,   1'b0, NO_TYPED},
      '{OP_SORTED,  32'h0000_0003, 7'd0,   1'b0, NO_TYPED},
      '{OP_AT,      32'hAAAA_AAAA, 7'd0,   1'b0, NO_TYPED},
      '{OP_REMOVE,  32'd12345,     7'd0,   1'b1, '{ST_NOT_FOUND, 7'd9, 1'b0, 1'b0}},
      '{OP_REMOVE,  32'h8000_0000, 7'd0,   1'b0, NO_TYPED},
      '{OP_REMOVE,  32'h7FFF_FFFF, 7'd0,   1'b0, NO_TYPED},
      '{OP_SPARE_A, 32'h0000_0007, 7'd127, 1'b0, NO_TYPED},
      '{OP_SPARE_B, 32'hFFFF_FFFF, 7'd0,   1'b0, NO_TYPED},
      '{OP_APPEND,  32'h5555_5555, 7'd0,   1'b0, NO_TYPED},
      '{OP_CLEAR,   32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      7'd0, 1'b1, 1'b0}},
      '{OP_CLEAR,   32'hFFFF_FFFF, 7'd127, 1'b1, '{ST_OK,      7'd0, 1'b1, 1'b0}},
      '{OP_REMOVE,  32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY,   7'd0, 1'b1, 1'b0}},
      '{OP_APPEND,  32'hFFFF_FFFF, 7'd0,   1'b1, '{ST_OK,      7'd1, 1'b0, 1'b0}},
      '{OP_REMOVE,  32'hFFFF_FFFF, 7'd0,   1'b1, '{ST_OK,      7'd0, 1'b1, 1'b0}},
      '{OP_FRONT,   32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      7'd1, 1'b0, 1'b0}}
    };

    // Hold reset, then release on a clock edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].pos,
                   $urandom_range(0, 17), dir_rows[i].typed, dir_rows[i].want);

    // Random traffic in fill, drain and mixed phases, with back-to-back bursts
    for (int n = 0; n < RANDOM_REQS; n++) begin
      phase = phase_e'((n / 100) % 3);
      draw_request(phase, op, key, pos);
      gap = (n % 120 < 25) ? 0 : $urandom_range(0, 17);
      send_request(op, key, pos, gap, 1'b0, NO_TYPED);
    end
    start_i <= 1'b0;

    // Wait for every owed result, then watch for stray strobes
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("ran %0d transactions, checked %0d results, %0d mismatches",
             requests_sent, results_checked, mismatch_count);
    $display("answers seen: full %0d, empty %0d, not found %0d, bad position %0d",
             status_hits[ST_FULL], status_hits[ST_EMPTY], status_hits[ST_NOT_FOUND],
             status_hits[ST_BAD_POS]);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb_array_list_shift_engine: PASS");
    end else begin
      $display("tb_array_list_shift_engine: FAIL");
    end
    $finish;
  end

endmodule

// ===== array_list_shift_engine.f =====
+incdir+rtl
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/ale_ctrl.sv
rtl/array_list_shift_engine.sv
tb/sv/tb_array_list_shift_engine.sv
